/* design/srtf_pkg.sv */
// ----------------------------------------------------------------------------
// srtf_pkg
// shared sizes, state codes and the structs that run between the sequencer
// and the top level of the shortest-remaining-time-first schedule engine
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int MAX_JOBS    = 64;
  localparam int IDX_W       = $clog2(MAX_JOBS);
  localparam int CNT_W       = $clog2(MAX_JOBS + 1);
  localparam int VAL_W       = 12;
  localparam int TIME_W      = 19;
  localparam int JOB_IDX_W   = 6;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_APPLY  = 6'b001000,
    ST_OUT_RD = 6'b010000,
    ST_OUT_WR = 6'b100000
  } seq_state_t;

  // one shared read address, one shared write address, two job memories
  typedef struct packed {
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic              ab_we;
    logic              rem_we;
    logic [VAL_W-1:0]  arr_wdata;
    logic [VAL_W-1:0]  bur_wdata;
    logic [VAL_W-1:0]  rem_wdata;
    logic [TIME_W-1:0] cmp_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  arr;
    logic [VAL_W-1:0]  bur;
    logic [VAL_W-1:0]  rem;
    logic [TIME_W-1:0] cmp;
  } mem_rsp_t;

  // one finished job on its way to the output register
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] cmp;
    logic [VAL_W-1:0]  arr;
    logic [VAL_W-1:0]  bur;
    logic              last;
  } res_t;

endpackage

/* design/srtf_schedule_simulator.sv */
// ----------------------------------------------------------------------------
// srtf_schedule_simulator
// preemptive shortest-remaining-time-first schedule engine over a job list
// ----------------------------------------------------------------------------
// load: jobs load one word per cycle; the word with tlast starts the run
// run: each scheduling event is one memory scan plus decide and write-back;
//   at most about three events per job
// results: a read state and a write state per word through the shared memory read port
// reset: synchronous active-low rst_n clears control state; job memories
//   hold no reset value and are only read below the loaded job count
// ----------------------------------------------------------------------------
module srtf_schedule_simulator
  import srtf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input words, one per job
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // arrival[11:0], burst[23:12]
  input  logic                   in_tlast,   // is_last
  // result words, one per job in load order
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // job_index[5:0], completion[24:6],
                                             // waiting[43:25],
                                             // turnaround[62:44], zero pad[63]
  output logic                   out_tlast   // last_result
);

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;
  res_t     res;
  logic     res_push;
  logic     res_slot_free;

  // output register, decouples the sequencer from the result sink
  logic                   out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [TIME_W-1:0]      turnaround;
  logic [TIME_W-1:0]      waiting;

  // arrival and burst share one memory word, written at load time only
  logic [2*VAL_W-1:0] ab_rdata;
  // remaining service and completion tick share the other memory word
  logic [VAL_W+TIME_W-1:0] rc_rdata;

  srtf_ram #(.DATA_W(2*VAL_W), .DEPTH(MAX_JOBS)) u_ab_ram (
    .clk   (clk),
    .we    (mem_req.ab_we),
    .waddr (mem_req.wr_addr),
    .wdata ({mem_req.bur_wdata, mem_req.arr_wdata}),
    .raddr (mem_req.rd_addr),
    .rdata (ab_rdata)
  );

  // read-modify-written once per scheduling event; the completion field is
  // final once the remaining field reaches zero
  srtf_ram #(.DATA_W(VAL_W+TIME_W), .DEPTH(MAX_JOBS)) u_rc_ram (
    .clk   (clk),
    .we    (mem_req.rem_we),
    .waddr (mem_req.wr_addr),
    .wdata ({mem_req.cmp_wdata, mem_req.rem_wdata}),
    .raddr (mem_req.rd_addr),
    .rdata (rc_rdata)
  );

  assign mem_rsp.arr = ab_rdata[VAL_W-1:0];
  assign mem_rsp.bur = ab_rdata[2*VAL_W-1:VAL_W];
  assign mem_rsp.rem = rc_rdata[VAL_W-1:0];
  assign mem_rsp.cmp = rc_rdata[VAL_W+TIME_W-1:VAL_W];

  // write-back and the next scan never share a cycle, so the state order
  // itself is the interlock on the remaining-time memory
  srtf_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_arrival    (in_tdata[VAL_W-1:0]),
    .in_burst      (in_tdata[2*VAL_W-1:VAL_W]),
    .in_last       (in_tlast),
    .in_ready      (in_tready),
    .mem_req       (mem_req),
    .mem_rsp       (mem_rsp),
    .res_push      (res_push),
    .res           (res),
    .res_slot_free (res_slot_free)
  );

  assign res_slot_free = !out_vld_r || out_tready;

  // turnaround = completion - arrival, waiting = turnaround - burst
  assign turnaround = res.cmp - TIME_W'(res.arr);
  assign waiting    = turnaround - TIME_W'(res.bur);

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    if (res_push) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = {1'b0, turnaround, waiting, res.cmp, JOB_IDX_W'(res.idx)};
      out_last_nxt = res.last;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* design/srtf_ram.sv */
// ----------------------------------------------------------------------------
// srtf_ram
// generic simple dual-port synchronous ram, one write and one registered read
// ----------------------------------------------------------------------------
module srtf_ram #(
  parameter int DATA_W = 12,
  parameter int DEPTH  = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/srtf_seq.sv */
// ----------------------------------------------------------------------------
// srtf_seq
// sequencer: loads jobs, scans the job memories for the next event, applies
// the run of the picked job and reads the results back out in job order
// ----------------------------------------------------------------------------
module srtf_seq
  import srtf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [VAL_W-1:0] in_arrival,
  input  logic [VAL_W-1:0] in_burst,
  input  logic             in_last,
  output logic             in_ready,
  output mem_req_t         mem_req,
  input  mem_rsp_t         mem_rsp,
  output logic             res_push,
  output res_t             res,
  input  logic             res_slot_free
);

  seq_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  done_r, done_nxt;
  logic [TIME_W-1:0] t_r, t_nxt;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              found_r, found_nxt;
  logic [VAL_W-1:0]  best_r, best_nxt;
  logic [IDX_W-1:0]  pick_r, pick_nxt;
  logic              pend_r, pend_nxt;
  logic [VAL_W-1:0]  next_r, next_nxt;
  logic [VAL_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;

  logic [CNT_W-1:0]  last_idx;
  logic [VAL_W-1:0]  bur_fix;
  logic              room;
  logic              arrived;
  logic              hit_run;
  logic              hit_pend;
  logic [TIME_W-1:0] gap;
  logic [VAL_W-1:0]  rem_new;
  logic [TIME_W-1:0] t_plus_k;

  assign last_idx = count_r - CNT_W'(1);
  assign bur_fix  = (in_burst == '0) ? VAL_W'(1) : in_burst;
  assign room     = (count_r < CNT_W'(MAX_JOBS));
  assign arrived  = (TIME_W'(mem_rsp.arr) <= t_r);
  // unfinished and ready: candidate to run; unfinished and not yet here: next event
  assign hit_run  = (mem_rsp.rem != '0) && arrived && (!found_r || mem_rsp.rem < best_r);
  assign hit_pend = (mem_rsp.rem != '0) && !arrived && (!pend_r || mem_rsp.arr < next_r);
  assign gap      = TIME_W'(next_r) - t_r;
  assign rem_new  = best_r - k_r;
  assign t_plus_k = t_r + TIME_W'(k_r);

  assign in_ready = (state_r == ST_LOAD);
  assign res_push = (state_r == ST_OUT_WR) && res_slot_free;

  always_comb begin
    res.idx  = out_idx_r;
    res.cmp  = mem_rsp.cmp;
    res.arr  = mem_rsp.arr;
    res.bur  = mem_rsp.bur;
    res.last = (CNT_W'(out_idx_r) == last_idx);
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    done_nxt     = done_r;
    t_nxt        = t_r;
    scan_idx_nxt = scan_idx_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = scan_idx_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    pick_nxt     = pick_r;
    pend_nxt     = pend_r;
    next_nxt     = next_r;
    k_nxt        = k_r;
    out_idx_nxt  = out_idx_r;
    mem_req      = '0;

    case (state_r)
      ST_LOAD: begin
        mem_req.wr_addr   = count_r[IDX_W-1:0];
        mem_req.arr_wdata = in_arrival;
        mem_req.bur_wdata = bur_fix;
        mem_req.rem_wdata = bur_fix;
        if (in_valid) begin
          if (room) begin
            mem_req.ab_we  = 1'b1;
            mem_req.rem_we = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
          end
          if (in_last) begin
            state_nxt    = ST_SCAN;
            t_nxt        = '0;
            done_nxt     = '0;
            scan_idx_nxt = '0;
            found_nxt    = 1'b0;
            pend_nxt     = 1'b0;
          end
        end
      end

      ST_SCAN: begin
        mem_req.rd_addr = scan_idx_r[IDX_W-1:0];
        if (scan_idx_r < count_r) begin
          rd_vld_nxt   = 1'b1;
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          if (hit_run) begin
            found_nxt = 1'b1;
            best_nxt  = mem_rsp.rem;
            pick_nxt  = rd_idx_r[IDX_W-1:0];
          end
          if (hit_pend) begin
            pend_nxt = 1'b1;
            next_nxt = mem_rsp.arr;
          end
          if (rd_idx_r == last_idx) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        // the picked job keeps the lead until the next arrival or its own end
        if (found_r) begin
          k_nxt     = (pend_r && gap < TIME_W'(best_r)) ? gap[VAL_W-1:0] : best_r;
          state_nxt = ST_APPLY;
        end else if (pend_r) begin
          t_nxt        = TIME_W'(next_r);
          state_nxt    = ST_SCAN;
          scan_idx_nxt = '0;
          pend_nxt     = 1'b0;
        end else begin
          state_nxt   = ST_OUT_RD;
          out_idx_nxt = '0;
        end
      end

      ST_APPLY: begin
        // completion tick rides along; the write that empties the job is the last
        mem_req.wr_addr   = pick_r;
        mem_req.rem_we    = 1'b1;
        mem_req.rem_wdata = rem_new;
        mem_req.cmp_wdata = t_plus_k;
        t_nxt             = t_plus_k;
        scan_idx_nxt      = '0;
        found_nxt         = 1'b0;
        pend_nxt          = 1'b0;
        state_nxt         = ST_SCAN;
        if (rem_new == '0) begin
          done_nxt = done_r + CNT_W'(1);
          if (done_r == last_idx) begin
            state_nxt   = ST_OUT_RD;
            out_idx_nxt = '0;
          end
        end
      end

      ST_OUT_RD: begin
        mem_req.rd_addr = out_idx_r;
        state_nxt       = ST_OUT_WR;
      end

      ST_OUT_WR: begin
        // address held, so the read data stays put while the output stalls
        mem_req.rd_addr = out_idx_r;
        if (res_slot_free) begin
          if (res.last) begin
            state_nxt = ST_LOAD;
            count_nxt = '0;
          end else begin
            out_idx_nxt = out_idx_r + IDX_W'(1);
            state_nxt   = ST_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      count_r  <= '0;
      done_r   <= '0;
      t_r      <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      done_r   <= done_nxt;
      t_r      <= t_nxt;
      rd_vld_r <= rd_vld_nxt;
      found_r  <= found_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    next_r     <= next_nxt;
    k_r        <= k_nxt;
    out_idx_r  <= out_idx_nxt;
  end

endmodule

/* design/srtf_checker.sv */
// ----------------------------------------------------------------------------
// srtf_checker
// port-level checks on the schedule engine, bound to the top level
// ----------------------------------------------------------------------------
module srtf_checker
  import srtf_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  logic [TIME_W-1:0] chk_cmp;
  logic [TIME_W-1:0] chk_wait;
  logic [TIME_W-1:0] chk_turn;

  assign chk_cmp  = out_tdata[24:6];
  assign chk_wait = out_tdata[43:25];
  assign chk_turn = out_tdata[62:44];

  // no result word right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // the closing job word starts the run, so input stops at once
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still ready after the closing job word");

  // every job runs at least one tick after arriving
  a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (chk_turn <= chk_cmp) && (chk_wait < chk_turn) && (chk_turn != '0))
    else $error("result times out of order");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result word changed");

endmodule

bind srtf_schedule_simulator srtf_checker u_srtf_checker (.*);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// checks the shortest-remaining-time-first schedule engine: job lists go in
// one word per job, an in-bench scheduler works out each job's completion,
// waiting and turnaround time, and every result word is compared in order
// ----------------------------------------------------------------------------
module testbench;
  import srtf_pkg::*;

  // expected result for one finished job
  typedef struct packed {
    logic [JOB_IDX_W-1:0] idx;
    logic [TIME_W-1:0]    completion;
    logic [TIME_W-1:0]    waiting;
    logic [TIME_W-1:0]    turnaround;
    logic                 final_job;
  } job_report_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // arrival[11:0], burst[23:12]
  logic                   in_tlast;   // is_last
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // job_index[5:0], completion[24:6],
                                      // waiting[43:25],
                                      // turnaround[62:44], zero pad[63]
  logic                   out_tlast;  // last_result

  srtf_schedule_simulator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // job list being loaded, as the scheduler sees it (bursts already raised)
  logic [VAL_W-1:0] list_arrival [MAX_JOBS];
  logic [VAL_W-1:0] list_burst   [MAX_JOBS];
  int unsigned      list_count;

  job_report_t pending_reports [$];
  int unsigned mismatch_cnt;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // safety net in case the engine hangs
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // in-bench scheduler: runs the loaded list and queues one report per job.
  // between arrivals the running job keeps the least remaining time, so it
  // runs on until it finishes or the next arrival can preempt it
  task automatic schedule_list();
    int unsigned left   [MAX_JOBS];
    int unsigned finish [MAX_JOBS];
    int unsigned now;
    int unsigned finished;
    int unsigned next_arr;
    int unsigned slice;
    int          pick;
    job_report_t rpt;
    now = 0;
    finished = 0;
    for (int i = 0; i < list_count; i++) left[i] = list_burst[i];
    while (finished < list_count) begin
      pick = -1;
      next_arr = 32'hFFFF_FFFF;
      for (int i = 0; i < list_count; i++) begin
        if (left[i] != 0 && list_arrival[i] <= now) begin
          if (pick < 0 || left[i] < left[pick]) pick = i;
        end else if (left[i] != 0 && list_arrival[i] < next_arr) begin
          next_arr = list_arrival[i];
        end
      end
      if (pick < 0) begin
        // nothing ready: jump straight to the earliest pending arrival
        now = next_arr;
      end else begin
        slice = left[pick];
        if (next_arr != 32'hFFFF_FFFF && next_arr - now < slice) slice = next_arr - now;
        left[pick] -= slice;
        now += slice;
        if (left[pick] == 0) begin
          finish[pick] = now;
          finished++;
        end
      end
    end
    for (int i = 0; i < list_count; i++) begin
      rpt.idx        = JOB_IDX_W'(i);
      rpt.completion = TIME_W'(finish[i]);
      rpt.turnaround = TIME_W'(finish[i] - list_arrival[i]);
      rpt.waiting    = TIME_W'(finish[i] - list_arrival[i] - list_burst[i]);
      rpt.final_job  = (i == list_count - 1);
      pending_reports.push_back(rpt);
    end
  endtask

  // one accepted job word: store it unless the list is full, run on tlast
  task automatic note_job(input logic [VAL_W-1:0] arr, input logic [VAL_W-1:0] bur,
                          input logic closes_list);
    if (list_count < MAX_JOBS) begin
      list_arrival[list_count] = arr;
      list_burst[list_count]   = (bur == 0) ? VAL_W'(1) : bur;
      list_count++;
    end
    if (closes_list) begin
      schedule_list();
      list_count = 0;
    end
  endtask

  // drive one job word; called and returns at a rising edge.
  // valid only drops when a gap is taken, so a back-to-back word never
  // sees valid lowered and raised in the same step
  task automatic send_job(input logic [VAL_W-1:0] arr, input logic [VAL_W-1:0] bur,
                          input logic closes_list);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bur, arr};
    in_tlast  <= closes_list;
    do @(posedge clk); while (!in_tready);
    note_job(arr, bur, closes_list);
  endtask

  // mostly extremes and small values so jobs collide, some full range
  function automatic logic [VAL_W-1:0] draw_tick();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return VAL_W'($urandom_range(0, 15));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // result side: check at the edge, then pick the next ready level
  always @(posedge clk) begin : result_check
    job_report_t got;
    job_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.idx        = out_tdata[5:0];
      got.completion = out_tdata[24:6];
      got.waiting    = out_tdata[43:25];
      got.turnaround = out_tdata[62:44];
      got.final_job  = out_tlast;
      if (pending_reports.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result word: job %0d completion %0d", got.idx,
                   got.completion);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("job %0d: expected cmp %0d wait %0d tat %0d last %0d", want.idx,
                     want.completion, want.waiting, want.turnaround, want.final_job);
            $display("  got job %0d cmp %0d wait %0d tat %0d last %0d", got.idx,
                     got.completion, got.waiting, got.turnaround, got.final_job);
          end
        end
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // lone jobs: zero burst raised to one, and both fields at their maximum
  task automatic test_single_jobs();
    send_job(12'd0, 12'd0, 1'b1);
    send_job(12'hFFF, 12'hFFF, 1'b1);
  endtask

  // a short job arriving mid-burst takes over the processor
  task automatic test_preemption();
    send_job(12'd0, 12'd8, 1'b0);
    send_job(12'd1, 12'd4, 1'b0);
    send_job(12'd2, 12'd9, 1'b0);
    send_job(12'd3, 12'd5, 1'b1);
    send_job(12'd0, 12'hFFF, 1'b0);
    send_job(12'd1, 12'd1, 1'b0);
    send_job(12'hFFF, 12'd1, 1'b1);
  endtask

  // equal remaining times go to the lowest index
  task automatic test_tie_break();
    send_job(12'd0, 12'd3, 1'b0);
    send_job(12'd0, 12'd3, 1'b0);
    send_job(12'd0, 12'd3, 1'b1);
  endtask

  // idle stretches before and between arrivals
  task automatic test_idle_gaps();
    send_job(12'd20, 12'd2, 1'b0);
    send_job(12'd5, 12'd1, 1'b0);
    send_job(12'd0, 12'd0, 1'b1);
    send_job(12'hFFF, 12'd0, 1'b0);
    send_job(12'hFFF, 12'hFFF, 1'b1);
  endtask

  // random lists, mostly short with the odd longer one
  task automatic test_random_lists(input int unsigned n_jobs);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_jobs) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      if (len > n_jobs - sent) len = n_jobs - sent;
      for (int i = 0; i < len; i++) send_job(draw_tick(), draw_tick(), i == len - 1);
      sent += len;
    end
  endtask

  // a full list, then words past capacity: a dropped word without tlast,
  // then a dropped word with tlast that still starts the run
  task automatic test_job_overflow();
    for (int i = 0; i < MAX_JOBS; i++)
      send_job(VAL_W'($urandom_range(0, 63)), VAL_W'($urandom_range(0, 20)), 1'b0);
    send_job(12'hFFF, 12'hFFF, 1'b0);
    send_job(draw_tick(), draw_tick(), 1'b1);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    list_count     = 0;
    mismatch_cnt   = 0;
    send_gap_pct   = 16;
    recv_stall_pct = 67;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver mostly stalled
    test_single_jobs();
    test_preemption();
    test_tie_break();
    test_idle_gaps();
    test_random_lists(12);

    // sender mostly idle, receiver mostly ready
    send_gap_pct   = 67;
    recv_stall_pct = 16;
    test_random_lists(12);
    test_job_overflow();

    // full rate both ways
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_lists(12);
    in_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    // then wait on to catch stray words
    repeat (200) @(posedge clk);
    if (pending_reports.size() != 0)
      $display("%0d expected result words never arrived", pending_reports.size());
    if (mismatch_cnt == 0 && pending_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
